>>> rtl/sme_pkg.sv
// Types and constants shared by the stack machine execute block.
`default_nettype none

package sme_pkg;

  localparam int DATA_W     = 32;
  localparam int SYM_W      = 8;
  // Program space is a power of two, so the pc wraps on its own width.
  localparam int PC_W       = 10;
  localparam int PROG_DEPTH = 1 << PC_W;

  typedef enum logic [3:0] {
    ACT_NOP      = 4'd0,
    ACT_PUSH_IMM = 4'd1,
    ACT_PUSH_X   = 4'd2,
    ACT_POP_X    = 4'd3,
    ACT_ADD      = 4'd4,
    ACT_SUB      = 4'd5,
    ACT_MULT     = 4'd6,
    ACT_EQUAL    = 4'd7,
    ACT_JMP      = 4'd8,
    ACT_JMPZ     = 4'd9,
    ACT_JMPNZ    = 4'd10,
    ACT_EDIT     = 4'd11,
    ACT_HALT     = 4'd12
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNDERFLOW  = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_HALTED     = 3'd3,
    ST_EDIT_RANGE = 3'd4
  } status_t;

endpackage

`default_nettype wire

>>> rtl/stack_machine_execute.sv
// A word taken into the input register has its result held in the result register.
// One instruction per cycle while not stalled; top two stack entries live in registers and
// the rest in a one-write, one-read memory whose registered read is the third entry.
// Reset (synchronous, active low) empties the stack, zeroes x and pc, clears halt.
// The stack memory is not cleared; no entry's value is used before it is written.
`default_nettype none

module stack_machine_execute #(
  parameter int STACK_DEPTH = 64,
  parameter int OUT_DEPTH   = 128,
  localparam int SP_W       = $clog2(STACK_DEPTH + 1),
  localparam int OUT_W      = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [3:0]                in_action,
  input  wire logic signed [31:0]        in_operand,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [sme_pkg::PC_W-1:0]       out_next_pc,
  output logic signed [31:0]             out_top_value,
  output logic [SP_W-1:0]                out_stack_depth,
  output logic [2:0]                     out_status,
  output logic                           out_edit_valid,
  output logic [OUT_W-1:0]               out_edit_position,
  output logic [sme_pkg::SYM_W-1:0]      out_edit_symbol,
  output logic                           out_halted_flag
);
  import sme_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  // input register
  logic                s1_valid_r;
  action_t             s1_act_r;
  logic [DATA_W-1:0]   s1_opnd_r;

  // architectural state
  logic [SP_W-1:0]     sp_r, sp_nxt;
  logic [DATA_W-1:0]   tos_r, tos_nxt;
  logic [DATA_W-1:0]   nos_r, nos_nxt;
  logic [DATA_W-1:0]   third_r;
  logic [DATA_W-1:0]   x_r, x_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic                halt_r, halt_nxt;
  logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];

  // result register
  logic                out_valid_r;
  logic [PC_W-1:0]     out_pc_r;
  logic [DATA_W-1:0]   out_top_r;
  logic [SP_W-1:0]     out_depth_r;
  status_t             out_status_r;
  logic                out_ev_r;
  logic [OUT_W-1:0]    out_epos_r;
  logic [SYM_W-1:0]    out_esym_r;
  logic                out_halt_r;

  logic                adv;
  logic [1:0]          need;
  logic                pushes;
  logic [DATA_W-1:0]   push_val;
  logic [DATA_W-1:0]   alu_val;
  logic [DATA_W-1:0]   mul_lo;
  status_t             status_nxt;
  logic                ev_nxt;
  logic [OUT_W-1:0]    epos_nxt;
  logic [SYM_W-1:0]    esym_nxt;
  logic                mem_we;
  logic [SP_W-1:0]     wr_sp;
  logic [SP_W-1:0]     rd_sp;
  logic [AW-1:0]       mem_wa;
  logic [AW-1:0]       mem_ra;
  logic                edit_bad;
  logic                take_jump;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_act_r  <= action_t'(in_action);
      s1_opnd_r <= DATA_W'(in_operand);
    end
  end

  assign mul_lo    = tos_r * nos_r;
  assign edit_bad  = tos_r >= DATA_W'(OUT_DEPTH);
  assign take_jump = (s1_act_r == ACT_JMPZ) == (tos_r == '0);
  assign push_val  = (s1_act_r == ACT_PUSH_X) ? x_r : s1_opnd_r;
  assign wr_sp     = sp_r - SP_W'(2);
  assign rd_sp     = sp_nxt - SP_W'(3);
  assign mem_wa    = wr_sp[AW-1:0];
  assign mem_ra    = rd_sp[AW-1:0];

  always_comb begin
    case (s1_act_r)
      ACT_ADD:   alu_val = tos_r + nos_r;
      ACT_SUB:   alu_val = tos_r - nos_r;
      ACT_MULT:  alu_val = mul_lo;
      ACT_EQUAL: alu_val = (tos_r == nos_r) ? DATA_W'(1) : '0;
      default:   alu_val = '0;
    endcase
  end

  always_comb begin
    case (s1_act_r)
      ACT_POP_X, ACT_JMPZ, ACT_JMPNZ, ACT_EDIT: need = 2'd1;
      ACT_ADD, ACT_SUB, ACT_MULT, ACT_EQUAL:    need = 2'd2;
      default:                                  need = 2'd0;
    endcase
    pushes = (s1_act_r == ACT_PUSH_IMM) || (s1_act_r == ACT_PUSH_X);
  end

  always_comb begin
    status_nxt = ST_OK;
    ev_nxt     = 1'b0;
    epos_nxt   = '0;
    esym_nxt   = '0;
    pc_nxt     = pc_r;
    sp_nxt     = sp_r;
    tos_nxt    = tos_r;
    nos_nxt    = nos_r;
    x_nxt      = x_r;
    halt_nxt   = halt_r;
    mem_we     = 1'b0;
    if (halt_r) begin
      status_nxt = ST_HALTED;
    end else if (sp_r < SP_W'(need)) begin
      status_nxt = ST_UNDERFLOW;
    end else if (pushes && sp_r >= SP_W'(STACK_DEPTH)) begin
      status_nxt = ST_OVERFLOW;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
      case (s1_act_r)
        ACT_PUSH_IMM, ACT_PUSH_X: begin
          // spill the old second entry into memory
          mem_we  = sp_r >= SP_W'(2);
          nos_nxt = tos_r;
          tos_nxt = push_val;
          sp_nxt  = sp_r + SP_W'(1);
        end
        ACT_POP_X: begin
          x_nxt   = tos_r;
          tos_nxt = nos_r;
          nos_nxt = third_r;
          sp_nxt  = sp_r - SP_W'(1);
        end
        ACT_ADD, ACT_SUB, ACT_MULT, ACT_EQUAL: begin
          tos_nxt = alu_val;
          nos_nxt = third_r;
          sp_nxt  = sp_r - SP_W'(1);
        end
        ACT_JMP: begin
          pc_nxt = s1_opnd_r[PC_W-1:0];
        end
        ACT_JMPZ, ACT_JMPNZ: begin
          tos_nxt = nos_r;
          nos_nxt = third_r;
          sp_nxt  = sp_r - SP_W'(1);
          if (take_jump) begin
            pc_nxt = s1_opnd_r[PC_W-1:0];
          end
        end
        ACT_EDIT: begin
          if (edit_bad) begin
            status_nxt = ST_EDIT_RANGE;
            pc_nxt     = pc_r;
          end else begin
            tos_nxt  = nos_r;
            nos_nxt  = third_r;
            sp_nxt   = sp_r - SP_W'(1);
            ev_nxt   = 1'b1;
            epos_nxt = tos_r[OUT_W-1:0];
            esym_nxt = s1_opnd_r[SYM_W-1:0];
          end
        end
        ACT_HALT: begin
          halt_nxt   = 1'b1;
          status_nxt = ST_HALTED;
          pc_nxt     = pc_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      x_r    <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
    end else if (adv) begin
      sp_r   <= sp_nxt;
      x_r    <= x_nxt;
      pc_r   <= pc_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tos_r <= tos_nxt;
      nos_r <= nos_nxt;
    end
  end

  // third entry tracks the memory at the new depth, bypassing a same-cycle spill
  always_ff @(posedge clk) begin
    if (adv) begin
      if (mem_we) begin
        stack_mem[mem_wa] <= nos_r;
      end
      third_r <= (mem_we && mem_wa == mem_ra) ? nos_r : stack_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pc_r     <= pc_nxt;
      out_top_r    <= (sp_nxt != '0) ? tos_nxt : '0;
      out_depth_r  <= sp_nxt;
      out_status_r <= status_nxt;
      out_ev_r     <= ev_nxt;
      out_epos_r   <= epos_nxt;
      out_esym_r   <= esym_nxt;
      out_halt_r   <= halt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_pc_r;
  assign out_top_value     = $signed(out_top_r);
  assign out_stack_depth   = out_depth_r;
  assign out_status        = out_status_r;
  assign out_edit_valid    = out_ev_r;
  assign out_edit_position = out_epos_r;
  assign out_edit_symbol   = out_esym_r;
  assign out_halted_flag   = out_halt_r;

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt mark cleared");

  a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_halt_r |-> out_status_r == ST_HALTED)
    else $error("halted result without halted status");

  a_edit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> out_status_r == ST_OK)
    else $error("edit word with fault status");

  a_fault_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    adv && status_nxt != ST_OK |=> pc_r == $past(pc_r) && sp_r == $past(sp_r))
    else $error("faulted step changed pc or depth");
`endif

endmodule

`default_nettype wire
